/* src/swpc_pkg.sv */
// ----------------------------------------------------------------------------
// swpc_pkg
// Shared types, constants and the coil phase decoder for the filter wheel
// stepper position controller.
// ----------------------------------------------------------------------------
package swpc_pkg;

  localparam int unsigned POS_W     = 4;
  localparam int unsigned SPP_W     = 12;
  localparam int unsigned HLIM_W    = 13;
  localparam int unsigned STEPS_W   = 14;
  localparam int unsigned DUTY_W    = 14;
  localparam int unsigned CUR_W     = 16;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned COILS_W   = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 13;

  localparam int unsigned WHEEL_POSITIONS_DEF = 9;
  localparam int unsigned DUTY_FULL_SCALE_DEF = 8499;

  localparam logic [SPP_W-1:0]  SPP_RST  = SPP_W'(455);
  localparam logic [HLIM_W-1:0] HLIM_RST = HLIM_W'(4096);

  // 80 mA in 1/256 mA units
  localparam int unsigned CUR_MAX   = 20480;
  localparam int unsigned CUR_MAX_W = 15;
  localparam int unsigned DUTY_FRAC = 29;
  localparam int unsigned RECIP_W   = 31;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 3'd0,
    KIND_GOTO    = 3'd1,
    KIND_HOME    = 3'd2,
    KIND_LED_ON  = 3'd3,
    KIND_LED_OFF = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_NONE     = 3'd0,
    STATUS_DONE     = 3'd1,
    STATUS_TIMEOUT  = 3'd2,
    STATUS_BUSY     = 3'd3,
    STATUS_LID_OPEN = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_HOME      = 2'd1,
    MODE_HOME_GOTO = 2'd2,
    MODE_MOVE      = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEPS_PER_POS = 1'd0,
    CFG_HOME_LIMIT    = 1'd1
  } cfg_idx_e;

  function automatic logic [COILS_W-1:0] coil_pattern(logic [PHASE_W-1:0] ph);
    logic [COILS_W-1:0] pat;
    unique case (ph)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h5;
      3'd2:    pat = 4'h4;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h2;
      3'd5:    pat = 4'hA;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

/* src/stepper_wheel_position_controller.sv */
// ----------------------------------------------------------------------------
// stepper_wheel_position_controller
// Filter wheel indexer: homing search, shortest-way goto, half-step coil
// phase generator and lid-interlocked LED current setting.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------
//   in       | sink      | in_valid_i/in_ready_o | kind, target, sensor, lid, current
//   out      | source    | out_valid_o/out_ready_i | coils .. duty
//   cfg      | sink      | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// Each transaction updates the state registers and the result register on
// the accepting edge; a new transaction is taken every cycle unless the
// result register is held. The result register is the only stall point;
// while it is held, in_ready_o drops. Reset initialises all state, no warm-up.
// ----------------------------------------------------------------------------
module stepper_wheel_position_controller import swpc_pkg::*; #(
  parameter int unsigned WHEEL_POSITIONS = WHEEL_POSITIONS_DEF,
  parameter int unsigned DUTY_FULL_SCALE = DUTY_FULL_SCALE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [POS_W-1:0]     target_i,
  input  logic                 home_sensor_i,
  input  logic                 lid_closed_i,
  input  logic [CUR_W-1:0]     current_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [COILS_W-1:0]   coils_o,
  output logic [POS_W-1:0]     position_o,
  output logic                 homed_o,
  output logic                 moving_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic                 led_enable_o,
  output logic [2:0]           led_channel_o,
  output logic [DUTY_W-1:0]    duty_o
);

  localparam logic [POS_W-1:0] BlankPos = POS_W'(WHEEL_POSITIONS - 1);
  localparam logic [POS_W:0]   NumPos   = (POS_W+1)'(WHEEL_POSITIONS);
  localparam logic [POS_W-1:0] HalfRing = POS_W'((WHEEL_POSITIONS - 1) / 2);
  localparam longint unsigned  DutyRecipL =
    ((longint'(DUTY_FULL_SCALE) << DUTY_FRAC) + longint'(CUR_MAX) - 1) / longint'(CUR_MAX);
  localparam logic [RECIP_W-1:0] DutyRecip = RECIP_W'(DutyRecipL);

  logic [SPP_W-1:0]   spp_q;
  logic [HLIM_W-1:0]  hlim_q;
  logic [POS_W-1:0]   wp_q, wp_d;
  logic               homed_q, homed_d;
  mode_e              mode_q, mode_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [STEPS_W-1:0] steps_q, steps_d;
  logic               dir_q, dir_d;
  logic [POS_W-1:0]   pend_q, pend_d;
  logic [HLIM_W-1:0]  hst_q, hst_d;
  logic               led_q, led_d;
  logic [DUTY_W-1:0]  duty_q, duty_d;
  logic               out_valid_q;
  logic [COILS_W-1:0] coils_q, coils_d;
  status_e            status_q, status_d;

  logic                accept;
  logic [POS_W-1:0]    tgt_sat;
  logic [POS_W-1:0]    plan_tgt, plan_wp;
  logic [POS_W:0]      ring_sum, ring_diff;
  logic [POS_W-1:0]    diff, span;
  logic                plan_dir;
  logic [POS_W+SPP_W-1:0] plan_prod;
  logic [STEPS_W-1:0]  plan_steps;
  logic                plan_zero;
  logic                homing, home_timeout;
  logic [STEPS_W-1:0]  move_left;
  logic                move_last;
  logic                stepping;
  logic [CUR_MAX_W-1:0] cur_clamp;
  logic [CUR_MAX_W+RECIP_W-1:0] duty_prod;
  logic [DUTY_W-1:0]   duty_calc;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;

  assign tgt_sat = ({1'b0, target_i} >= NumPos) ? BlankPos : target_i;

  // shortest way around the ring
  assign plan_tgt  = (mode_q == MODE_HOME_GOTO) ? pend_q : tgt_sat;
  assign plan_wp   = (mode_q == MODE_HOME_GOTO) ? BlankPos : wp_q;
  assign ring_sum  = {1'b0, plan_tgt} + NumPos - {1'b0, plan_wp};
  assign ring_diff = (ring_sum >= NumPos) ? ring_sum - NumPos : ring_sum;
  assign diff      = ring_diff[POS_W-1:0];
  assign plan_dir  = diff > HalfRing;
  assign span      = plan_dir ? POS_W'(NumPos - {1'b0, diff}) : diff;
  assign plan_prod = {{SPP_W{1'b0}}, span} * {{POS_W{1'b0}}, spp_q};
  assign plan_steps = plan_prod[STEPS_W-1:0];
  assign plan_zero  = plan_steps == '0;

  assign homing       = (mode_q == MODE_HOME) || (mode_q == MODE_HOME_GOTO);
  assign home_timeout = hst_q >= hlim_q;
  assign move_left    = (steps_q != '0) ? steps_q - STEPS_W'(1) : '0;
  assign move_last    = move_left == '0;

  assign cur_clamp = (current_i > CUR_W'(CUR_MAX)) ? CUR_MAX_W'(CUR_MAX)
                                                    : current_i[CUR_MAX_W-1:0];
  assign duty_prod = {{RECIP_W{1'b0}}, cur_clamp} * {{CUR_MAX_W{1'b0}}, DutyRecip};
  assign duty_calc = duty_prod[DUTY_FRAC +: DUTY_W];

  // next state
  always_comb begin
    wp_d    = wp_q;
    homed_d = homed_q;
    mode_d  = mode_q;
    phase_d = phase_q;
    steps_d = steps_q;
    dir_d   = dir_q;
    pend_d  = pend_q;
    hst_d   = hst_q;
    led_d   = led_q;
    duty_d  = duty_q;
    unique case (kind_i)
      KIND_TICK: begin
        unique case (mode_q)
          MODE_HOME, MODE_HOME_GOTO: begin
            if (home_timeout) begin
              mode_d = MODE_IDLE;
            end else if (home_sensor_i) begin
              wp_d    = BlankPos;
              homed_d = 1'b1;
              if (mode_q == MODE_HOME) begin
                mode_d = MODE_IDLE;
              end else begin
                dir_d   = plan_dir;
                steps_d = plan_steps;
                if (plan_zero) begin
                  wp_d   = plan_tgt;
                  mode_d = MODE_IDLE;
                end else begin
                  mode_d = MODE_MOVE;
                end
              end
            end else begin
              phase_d = phase_q + PHASE_W'(1);
              hst_d   = hst_q + HLIM_W'(1);
            end
          end
          MODE_MOVE: begin
            phase_d = dir_q ? phase_q - PHASE_W'(1) : phase_q + PHASE_W'(1);
            steps_d = move_left;
            if (move_last) begin
              wp_d   = pend_q;
              mode_d = MODE_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      KIND_GOTO, KIND_HOME: begin
        if (mode_q == MODE_IDLE) begin
          if (kind_i == KIND_HOME) begin
            mode_d = MODE_HOME;
            hst_d  = '0;
          end else begin
            pend_d = tgt_sat;
            if (!homed_q) begin
              mode_d = MODE_HOME_GOTO;
              hst_d  = '0;
            end else begin
              dir_d   = plan_dir;
              steps_d = plan_steps;
              if (plan_zero) begin
                wp_d = plan_tgt;
              end else begin
                mode_d = MODE_MOVE;
              end
            end
          end
        end
      end
      KIND_LED_ON: begin
        if (lid_closed_i) begin
          duty_d = duty_calc;
          led_d  = 1'b1;
        end
      end
      KIND_LED_OFF: begin
        led_d  = 1'b0;
        duty_d = '0;
      end
      default: begin
      end
    endcase
  end

  // result
  assign stepping = (kind_i == KIND_TICK) &&
                    ((homing && !home_timeout && !home_sensor_i) || (mode_q == MODE_MOVE));

  always_comb begin
    coils_d  = stepping ? coil_pattern(phase_d) : '0;
    status_d = STATUS_NONE;
    unique case (kind_i)
      KIND_TICK: begin
        if (homing) begin
          if (home_timeout) begin
            status_d = STATUS_TIMEOUT;
          end else if (home_sensor_i && ((mode_q == MODE_HOME) || plan_zero)) begin
            status_d = STATUS_DONE;
          end
        end else if (mode_q == MODE_MOVE && move_last) begin
          status_d = STATUS_DONE;
        end
      end
      KIND_GOTO, KIND_HOME: begin
        if (mode_q != MODE_IDLE) begin
          status_d = STATUS_BUSY;
        end else if (kind_i == KIND_GOTO && homed_q && plan_zero) begin
          status_d = STATUS_DONE;
        end
      end
      KIND_LED_ON: begin
        if (!lid_closed_i) begin
          status_d = STATUS_LID_OPEN;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spp_q  <= SPP_RST;
      hlim_q <= HLIM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEPS_PER_POS: spp_q  <= cfg_wdata_i[SPP_W-1:0];
        default:           hlim_q <= cfg_wdata_i[HLIM_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= BlankPos;
      homed_q     <= 1'b0;
      mode_q      <= MODE_IDLE;
      phase_q     <= '0;
      steps_q     <= '0;
      dir_q       <= 1'b0;
      pend_q      <= BlankPos;
      hst_q       <= '0;
      led_q       <= 1'b0;
      duty_q      <= '0;
      out_valid_q <= 1'b0;
      coils_q     <= '0;
      status_q    <= STATUS_NONE;
    end else begin
      if (accept) begin
        wp_q     <= wp_d;
        homed_q  <= homed_d;
        mode_q   <= mode_d;
        phase_q  <= phase_d;
        steps_q  <= steps_d;
        dir_q    <= dir_d;
        pend_q   <= pend_d;
        hst_q    <= hst_d;
        led_q    <= led_d;
        duty_q   <= duty_d;
        coils_q  <= coils_d;
        status_q <= status_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign coils_o       = coils_q;
  assign position_o    = wp_q;
  assign homed_o       = homed_q;
  assign moving_o      = mode_q != MODE_IDLE;
  assign status_o      = status_q;
  assign led_enable_o  = led_q;
  assign led_channel_o = wp_q[2:0];
  assign duty_o        = duty_q;

endmodule

/* src/swpc_checker.sv */
// ----------------------------------------------------------------------------
// swpc_checker
// Port-level properties of the filter wheel controller, bound to the top.
// ----------------------------------------------------------------------------
module swpc_checker import swpc_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [CFG_W-1:0]     cfg_wdata_i,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [KIND_W-1:0]    kind_i,
  input logic [POS_W-1:0]     target_i,
  input logic                 home_sensor_i,
  input logic                 lid_closed_i,
  input logic [CUR_W-1:0]     current_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [COILS_W-1:0]   coils_o,
  input logic [POS_W-1:0]     position_o,
  input logic                 homed_o,
  input logic                 moving_o,
  input logic [STATUS_W-1:0]  status_o,
  input logic                 led_enable_o,
  input logic [2:0]           led_channel_o,
  input logic [DUTY_W-1:0]    duty_o
);

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_coils_only_in_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && coils_o != '0) |-> (moving_o || status_o == STATUS_DONE))
    else $error("coils driven outside motion");

  a_timeout_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_TIMEOUT) |-> !moving_o)
    else $error("still moving after home timeout");

  a_led_off_no_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !led_enable_o |-> duty_o == '0)
    else $error("duty set with LED disabled");

  a_channel_follows_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> led_channel_o == position_o[2:0])
    else $error("LED channel differs from wheel position");

endmodule

bind stepper_wheel_position_controller swpc_checker u_swpc_checker (.*);

/* tb/sv/wheel_indexer_checker.sv */
// ----------------------------------------------------------------------------
// wheel_indexer_checker
// Watches the command, result and register ports of the filter wheel
// indexer. Every accepted command runs through a cycle-free model of the
// homing search, the shortest-way move, the coil phase and the LED setting.
// Every accepted result is compared field by field with the oldest
// prediction. The mismatch count and the number of outstanding predictions
// go back to the testbench top.
// ----------------------------------------------------------------------------
module wheel_indexer_checker import swpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [POS_W-1:0]     target_i,
  input  logic                 home_sensor_i,
  input  logic                 lid_closed_i,
  input  logic [CUR_W-1:0]     current_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [COILS_W-1:0]   coils_i,
  input  logic [POS_W-1:0]     position_i,
  input  logic                 homed_i,
  input  logic                 moving_i,
  input  logic [STATUS_W-1:0]  status_i,
  input  logic                 led_enable_i,
  input  logic [2:0]           led_channel_i,
  input  logic [DUTY_W-1:0]    duty_i,
  output int unsigned          errors_o,
  output int unsigned          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_POS     = WHEEL_POSITIONS_DEF;
  localparam int unsigned BLANK_POS = N_POS - 1;
  localparam logic [31:0] COIL_SEQ  = 32'h98A2_6451;

  typedef struct packed {
    logic [COILS_W-1:0] coils;
    logic [POS_W-1:0]   position;
    logic               homed;
    logic               moving;
    status_e            status;
    logic               led_enable;
    logic [2:0]         led_channel;
    logic [DUTY_W-1:0]  duty;
  } wheel_result_t;

  logic [SPP_W-1:0]   spp_q;
  logic [HLIM_W-1:0]  hlim_q;
  logic [POS_W-1:0]   wheel_pos;
  logic               is_homed;
  mode_e              mode;
  logic [PHASE_W-1:0] phase;
  logic [STEPS_W-1:0] steps_to_go;
  logic               reverse;
  logic [POS_W-1:0]   goal_pos;
  logic [HLIM_W-1:0]  search_steps;
  logic               led_on;
  logic [DUTY_W-1:0]  duty_setting;

  wheel_result_t wheel_expect_q[$];
  wheel_result_t want;

  function automatic void clear_state();
    spp_q        = SPP_RST;
    hlim_q       = HLIM_RST;
    wheel_pos    = POS_W'(BLANK_POS);
    is_homed     = 1'b0;
    mode         = MODE_IDLE;
    phase        = '0;
    steps_to_go  = '0;
    reverse      = 1'b0;
    goal_pos     = POS_W'(BLANK_POS);
    search_steps = '0;
    led_on       = 1'b0;
    duty_setting = '0;
  endfunction

  // Returns 1 when the move is zero steps and finishes at once.
  function automatic bit launch_move();
    int unsigned diff;
    int unsigned span;
    diff = (goal_pos + N_POS - (wheel_pos % N_POS)) % N_POS;
    if (diff > (N_POS - 1) / 2) begin
      span    = N_POS - diff;
      reverse = 1'b1;
    end else begin
      span    = diff;
      reverse = 1'b0;
    end
    steps_to_go = STEPS_W'(span * spp_q);
    if (steps_to_go == '0) begin
      wheel_pos = goal_pos;
      mode      = MODE_IDLE;
      return 1'b1;
    end
    mode = MODE_MOVE;
    return 1'b0;
  endfunction

  function automatic wheel_result_t predict_wheel(logic [KIND_W-1:0] kind,
                                                  logic [POS_W-1:0] target,
                                                  logic sensor, logic lid,
                                                  logic [CUR_W-1:0] cur);
    wheel_result_t     r;
    logic [POS_W-1:0]  dest;
    longint unsigned   amps;
    r.coils  = '0;
    r.status = STATUS_NONE;
    dest     = (target >= N_POS) ? POS_W'(BLANK_POS) : target;
    case (kind)
      KIND_TICK: begin
        if (mode == MODE_HOME || mode == MODE_HOME_GOTO) begin
          if (search_steps >= hlim_q) begin
            mode     = MODE_IDLE;
            r.status = STATUS_TIMEOUT;
          end else if (sensor) begin
            wheel_pos = POS_W'(BLANK_POS);
            is_homed  = 1'b1;
            if (mode == MODE_HOME) begin
              mode     = MODE_IDLE;
              r.status = STATUS_DONE;
            end else if (launch_move()) begin
              r.status = STATUS_DONE;
            end
          end else begin
            phase        = phase + 1'b1;
            search_steps = search_steps + 1'b1;
            r.coils      = COIL_SEQ[phase*COILS_W +: COILS_W];
          end
        end else if (mode == MODE_MOVE) begin
          phase   = reverse ? phase - 1'b1 : phase + 1'b1;
          r.coils = COIL_SEQ[phase*COILS_W +: COILS_W];
          if (steps_to_go != '0) steps_to_go = steps_to_go - 1'b1;
          if (steps_to_go == '0) begin
            wheel_pos = goal_pos;
            mode      = MODE_IDLE;
            r.status  = STATUS_DONE;
          end
        end
      end
      KIND_GOTO, KIND_HOME: begin
        if (mode != MODE_IDLE) begin
          r.status = STATUS_BUSY;
        end else if (kind == KIND_HOME) begin
          mode         = MODE_HOME;
          search_steps = '0;
        end else begin
          goal_pos = dest;
          if (!is_homed) begin
            mode         = MODE_HOME_GOTO;
            search_steps = '0;
          end else if (launch_move()) begin
            r.status = STATUS_DONE;
          end
        end
      end
      KIND_LED_ON: begin
        if (!lid) begin
          r.status = STATUS_LID_OPEN;
        end else begin
          amps         = (cur > CUR_MAX) ? CUR_MAX : cur;
          duty_setting = DUTY_W'(amps * DUTY_FULL_SCALE_DEF / CUR_MAX);
          led_on       = 1'b1;
        end
      end
      KIND_LED_OFF: begin
        led_on       = 1'b0;
        duty_setting = '0;
      end
      default: ;
    endcase
    r.position    = wheel_pos;
    r.homed       = is_homed;
    r.moving      = (mode != MODE_IDLE);
    r.led_enable  = led_on;
    r.led_channel = wheel_pos[2:0];
    r.duty        = duty_setting;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_val,
                                      int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      errors_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      wheel_expect_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_STEPS_PER_POS) spp_q = cfg_wdata_i[SPP_W-1:0];
        else hlim_q = cfg_wdata_i[HLIM_W-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (wheel_expect_q.size() == 0) begin
          $error("result transaction with no command outstanding");
          errors_o++;
        end else begin
          want = wheel_expect_q.pop_front();
          check_field("coils", want.coils, coils_i);
          check_field("position", want.position, position_i);
          check_field("homed", want.homed, homed_i);
          check_field("moving", want.moving, moving_i);
          check_field("status", want.status, status_i);
          check_field("led_enable", want.led_enable, led_enable_i);
          check_field("led_channel", want.led_channel, led_channel_i);
          check_field("duty", want.duty, duty_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        wheel_expect_q.push_back(predict_wheel(kind_i, target_i, home_sensor_i,
                                               lid_closed_i, current_i));
      end
    end
    pending_o = wheel_expect_q.size();
  end

endmodule

/* tb/sv/tb_stepper_wheel_position_controller.sv */
// ----------------------------------------------------------------------------
// tb_stepper_wheel_position_controller
// Drives the filter wheel indexer with a directed opening (LED limits, lid
// interlock, busy rejection, homing success and timeout, a reverse move)
// and then random command streams under several register settings, with
// random idling on both sides, a stretch without idling and one long
// result back-pressure. Checking is done by wheel_indexer_checker.
// ----------------------------------------------------------------------------
module tb_stepper_wheel_position_controller;
  import swpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned IDLE_PCT       = 32;
  localparam int unsigned SQUEEZE_CYCLES = 300;
  localparam int unsigned N_POS          = WHEEL_POSITIONS_DEF;
  localparam int unsigned KIND_SPARE     = int'(KIND_LED_OFF) + 1;
  localparam int unsigned KIND_LAST      = (1 << KIND_W) - 1;
  localparam int unsigned TARGET_LAST    = (1 << POS_W) - 1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [KIND_W-1:0]    kind_i;
  logic [POS_W-1:0]     target_i;
  logic                 home_sensor_i;
  logic                 lid_closed_i;
  logic [CUR_W-1:0]     current_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [COILS_W-1:0]   coils_o;
  logic [POS_W-1:0]     position_o;
  logic                 homed_o;
  logic                 moving_o;
  logic [STATUS_W-1:0]  status_o;
  logic                 led_enable_o;
  logic [2:0]           led_channel_o;
  logic [DUTY_W-1:0]    duty_o;

  int unsigned mismatches;
  int unsigned outstanding;
  logic        steady;
  logic        squeeze_req;
  logic        squeeze_done;

  stepper_wheel_position_controller u_dut (.*);

  wheel_indexer_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .kind_i        (kind_i),
    .target_i      (target_i),
    .home_sensor_i (home_sensor_i),
    .lid_closed_i  (lid_closed_i),
    .current_i     (current_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .coils_i       (coils_o),
    .position_i    (position_o),
    .homed_i       (homed_o),
    .moving_i      (moving_o),
    .status_i      (status_o),
    .led_enable_i  (led_enable_o),
    .led_channel_i (led_channel_o),
    .duty_i        (duty_o),
    .errors_o      (mismatches),
    .pending_o     (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : result_sink
    int unsigned hold_left;
    hold_left    = 0;
    squeeze_done = 1'b0;
    out_ready_i  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        hold_left    = SQUEEZE_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic offer_cmd(logic [KIND_W-1:0] kind, logic [POS_W-1:0] target,
                           logic sensor, logic lid, logic [CUR_W-1:0] cur);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    target_i      <= target;
    home_sensor_i <= sensor;
    lid_closed_i  <= lid;
    current_i     <= cur;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic offer_random_cmd(int unsigned sensor_pct);
    int unsigned        pick;
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   target;
    logic [CUR_W-1:0]   cur;
    pick = $urandom_range(0, 99);
    if (pick < 66) kind = KIND_TICK;
    else if (pick < 78) kind = KIND_GOTO;
    else if (pick < 83) kind = KIND_HOME;
    else if (pick < 90) kind = KIND_LED_ON;
    else if (pick < 96) kind = KIND_LED_OFF;
    else kind = KIND_W'($urandom_range(KIND_SPARE, KIND_LAST));
    if ($urandom_range(0, 3) == 0) target = POS_W'($urandom_range(0, TARGET_LAST));
    else target = POS_W'($urandom_range(0, N_POS - 1));
    case ($urandom_range(0, 5))
      0:       cur = '0;
      1:       cur = CUR_W'(CUR_MAX);
      2:       cur = CUR_W'(CUR_MAX - 1);
      3:       cur = CUR_W'(CUR_MAX + 1);
      4:       cur = '1;
      default: cur = CUR_W'($urandom);
    endcase
    offer_cmd(kind, target, $urandom_range(0, 99) < sensor_pct,
              $urandom_range(0, 99) < 80, cur);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic set_wheel_config(logic [SPP_W-1:0] spp, logic [HLIM_W-1:0] hlim);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_STEPS_PER_POS;
    cfg_wdata_i <= CFG_W'(spp);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_HOME_LIMIT;
    cfg_wdata_i <= CFG_W'(hlim);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(logic [SPP_W-1:0] spp, logic [HLIM_W-1:0] hlim,
                           int unsigned items, int unsigned sensor_pct,
                           bit squeeze);
    set_wheel_config(spp, hlim);
    for (int unsigned i = 0; i < items; i++) begin
      steady <= squeeze && i >= 40 && i < 140;
      if (squeeze && i == 150) squeeze_req <= 1'b1;
      offer_random_cmd(sensor_pct);
    end
    steady <= 1'b0;
    drain();
  endtask

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_STEPS_PER_POS;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    kind_i        = KIND_TICK;
    target_i      = '0;
    home_sensor_i = 1'b0;
    lid_closed_i  = 1'b0;
    current_i     = '0;
    steady        = 1'b0;
    squeeze_req   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    offer_cmd(KIND_LED_ON, 4'd0, 1'b0, 1'b0, '1);
    offer_cmd(KIND_LED_ON, 4'd0, 1'b0, 1'b1, '0);
    offer_cmd(KIND_LED_ON, 4'd0, 1'b0, 1'b1, '1);
    offer_cmd(KIND_LED_ON, 4'd0, 1'b0, 1'b1, CUR_W'(CUR_MAX));
    offer_cmd(KIND_TICK, 4'd0, 1'b1, 1'b1, '0);
    offer_cmd(KIND_W'(KIND_SPARE), 4'd5, 1'b1, 1'b0, '1);
    offer_cmd(KIND_GOTO, POS_W'(TARGET_LAST), 1'b0, 1'b1, '0);
    offer_cmd(KIND_GOTO, 4'd3, 1'b0, 1'b1, '0);
    offer_cmd(KIND_HOME, 4'd0, 1'b0, 1'b1, '0);
    offer_cmd(KIND_TICK, 4'd0, 1'b0, 1'b1, '0);
    offer_cmd(KIND_TICK, 4'd0, 1'b1, 1'b1, '0);
    offer_cmd(KIND_GOTO, POS_W'(N_POS - 1), 1'b0, 1'b1, '0);
    offer_cmd(KIND_HOME, 4'd0, 1'b0, 1'b1, '0);
    offer_cmd(KIND_TICK, 4'd0, 1'b1, 1'b1, '0);
    drain();

    set_wheel_config(12'd1, 13'd2);
    offer_cmd(KIND_GOTO, 4'd4, 1'b0, 1'b1, '0);
    offer_cmd(KIND_TICK, 4'd0, 1'b0, 1'b1, '0);
    offer_cmd(KIND_TICK, 4'd0, 1'b1, 1'b1, '0);
    offer_cmd(KIND_TICK, 4'd0, 1'b0, 1'b1, '0);
    offer_cmd(KIND_TICK, 4'd0, 1'b0, 1'b1, '0);
    offer_cmd(KIND_GOTO, 4'd6, 1'b0, 1'b1, '0);
    offer_cmd(KIND_TICK, 4'd0, 1'b0, 1'b1, '0);
    offer_cmd(KIND_TICK, 4'd0, 1'b0, 1'b1, '0);
    offer_cmd(KIND_HOME, 4'd0, 1'b0, 1'b1, '0);
    offer_cmd(KIND_TICK, 4'd0, 1'b0, 1'b1, '0);
    offer_cmd(KIND_TICK, 4'd0, 1'b0, 1'b1, '0);
    offer_cmd(KIND_TICK, 4'd0, 1'b1, 1'b1, '0);
    offer_cmd(KIND_LED_OFF, 4'd0, 1'b0, 1'b0, '1);
    drain();

    run_phase(12'd1,    13'd1,    150, 10, 1'b0);
    run_phase(12'd3,    13'd8191, 200, 4,  1'b0);
    run_phase(12'd2,    13'd5,    250, 20, 1'b1);
    run_phase(12'd0,    13'd0,    80,  15, 1'b0);
    run_phase(12'd4,    13'd12,   250, 12, 1'b0);
    run_phase(12'd4095, 13'd30,   150, 10, 1'b0);

    repeat (4) @(negedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/swpc_pkg.sv
src/stepper_wheel_position_controller.sv
src/swpc_checker.sv
tb/sv/wheel_indexer_checker.sv
tb/sv/tb_stepper_wheel_position_controller.sv
